/* rtl/core/fdwv_pkg.sv */
`default_nettype none

package fdwv_pkg;

   // Item field widths
   localparam int FOOT_W     = 2;
   localparam int STANCE_W   = 32;
   localparam int DIFF_W     = 24;
   localparam int VAR_W      = 47;
   // A squared 24-bit difference never exceeds 2^46
   localparam int SQUARE_W   = 47;

   localparam int FOOT_COUNT        = 4;
   localparam int WINDOW_LENGTH_DEF = 12;
   localparam int QUEUE_DEPTH_DEF   = 2;

   localparam logic signed [DIFF_W-1:0] DIFF_MAX = 24'sh7FFFFF;
   localparam logic signed [DIFF_W-1:0] DIFF_MIN = 24'sh800000;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SUM,
      BK_SQ,
      BK_NQ,
      BK_PREP,
      BK_DIV,
      BK_OUT
   } bk_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

`default_nettype wire

/* rtl/core/fdwv_req_if.sv */
`default_nettype none

interface fdwv_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [fdwv_pkg::FOOT_W-1:0]            foot;
   logic signed [fdwv_pkg::STANCE_W-1:0]   stance_x;

   modport source (output valid, output foot, output stance_x, input ready);
   modport sink   (input valid, input foot, input stance_x, output ready);
endinterface

`default_nettype wire

/* rtl/core/fdwv_rsp_if.sv */
`default_nettype none

interface fdwv_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [fdwv_pkg::VAR_W-1:0]           variance;
   logic signed [fdwv_pkg::DIFF_W-1:0]   step_difference;

   modport source (output valid, output variance, output step_difference, input ready);
   modport sink   (input valid, input variance, input step_difference, output ready);
endinterface

`default_nettype wire

/* rtl/core/fdwv_queue.sv */
`default_nettype none

module fdwv_queue #(
   parameter int QUEUE_DEPTH = fdwv_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   input  wire logic signed [fdwv_pkg::DIFF_W-1:0]    push_data,
   input  wire logic                                  pop,
   output logic signed [fdwv_pkg::DIFF_W-1:0]         head,
   output fdwv_pkg::q_stat_type                       stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic signed [fdwv_pkg::DIFF_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Front must never write into a full queue, back never drain an empty one
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full || pop)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("queue read while empty");

endmodule

`default_nettype wire

/* rtl/core/fdwv_front.sv */
`default_nettype none

module fdwv_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   fdwv_req_if.sink                                 req,
   input  wire fdwv_pkg::q_stat_type                qstat,
   output logic                                     push,
   output logic signed [fdwv_pkg::DIFF_W-1:0]       push_data
);

   localparam int WIDE_W = fdwv_pkg::STANCE_W + 1;

   logic signed [fdwv_pkg::STANCE_W-1:0] prev_ff [fdwv_pkg::FOOT_COUNT];
   logic [fdwv_pkg::FOOT_COUNT-1:0]      seen_ff, seen_in;

   logic signed [fdwv_pkg::STANCE_W-1:0] prev_pos;
   logic signed [WIDE_W-1:0]             diff_wide;
   logic                                 in_range;

   assign req.ready = !qstat.full;
   assign push      = req.valid && req.ready;

   always_comb begin
      prev_pos  = prev_ff[req.foot];
      diff_wide = WIDE_W'(req.stance_x) - WIDE_W'(prev_pos);
      // In range when every bit above the 24-bit sign matches it
      in_range  = (diff_wide[WIDE_W-1:fdwv_pkg::DIFF_W-1] == '0) ||
                  (diff_wide[WIDE_W-1:fdwv_pkg::DIFF_W-1] == '1);
      if (!seen_ff[req.foot]) begin
         push_data = '0;
      end else if (in_range) begin
         push_data = diff_wide[fdwv_pkg::DIFF_W-1:0];
      end else if (diff_wide[WIDE_W-1]) begin
         push_data = fdwv_pkg::DIFF_MIN;
      end else begin
         push_data = fdwv_pkg::DIFF_MAX;
      end
      seen_in = seen_ff;
      if (push) begin
         seen_in[req.foot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         for (int i = 0; i < fdwv_pkg::FOOT_COUNT; i++) begin
            prev_ff[i] <= '0;
         end
      end else begin
         seen_ff <= seen_in;
         if (push) begin
            prev_ff[req.foot] <= req.stance_x;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/core/fdwv_back.sv */
`default_nettype none

module fdwv_back #(
   parameter int WINDOW_LENGTH = fdwv_pkg::WINDOW_LENGTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fdwv_pkg::q_stat_type                qstat,
   input  wire logic signed [fdwv_pkg::DIFF_W-1:0]  head,
   output logic                                     pop,
   fdwv_rsp_if.source                               rsp
);

   localparam int DIFF_W = fdwv_pkg::DIFF_W;
   localparam int SQR_W  = fdwv_pkg::SQUARE_W;
   localparam int VAR_W  = fdwv_pkg::VAR_W;
   localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
   localparam int SLOT_W = $clog2(WINDOW_LENGTH);
   localparam int SUM_W  = DIFF_W + FILL_W;
   localparam int SQ_W   = SQR_W + FILL_W;
   localparam int NQ_W   = FILL_W + SQ_W;
   localparam int NUM_W  = 2 * SUM_W;
   localparam int DEN_W  = 2 * FILL_W;
   localparam int CNT_W  = $clog2(NUM_W + 1);

   fdwv_pkg::bk_state_type state_ff, state_in;

   logic signed [DIFF_W-1:0] win_ff [WINDOW_LENGTH];
   logic signed [DIFF_W-1:0] rd_ff;
   logic signed [DIFF_W-1:0] d_ff;
   logic [SQR_W-1:0]         dsq_ff;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [NUM_W-1:0]         s2_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [NUM_W-1:0]         quo_ff;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [DEN_W-1:0]         den_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     rsp_valid_ff;
   logic [VAR_W-1:0]         rsp_var_ff;
   logic signed [DIFF_W-1:0] rsp_diff_ff;

   // Controls from the output decode
   logic win_we;
   logic out_load;
   logic div_last;

   logic                       full;
   logic signed [DIFF_W-1:0]   old;
   logic signed [2*DIFF_W-1:0] head_sq, old_sq;
   logic [SUM_W-1:0]           mag;
   logic [NQ_W-1:0]            nq;
   logic [DEN_W:0]             trial;
   logic                       ge;

   // Datapath combinational terms
   always_comb begin
      full    = (fill_ff == FILL_W'(WINDOW_LENGTH));
      old     = full ? rd_ff : '0;
      head_sq = (2*DIFF_W)'(head) * (2*DIFF_W)'(head);
      old_sq  = (2*DIFF_W)'(old) * (2*DIFF_W)'(old);
      sum_in  = sum_ff + SUM_W'(d_ff) - SUM_W'(old);
      sq_in   = sq_ff + SQ_W'(dsq_ff) - SQ_W'(old_sq[SQR_W-1:0]);
      fill_in = full ? fill_ff : fill_ff + FILL_W'(1);
      slot_in = (slot_ff == SLOT_W'(WINDOW_LENGTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
      mag     = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      nq      = NQ_W'(fill_ff) * NQ_W'(sq_ff);
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      ge      = (trial >= {1'b0, den_ff});
      rem_in  = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fdwv_pkg::BK_IDLE: if (!qstat.empty) state_in = fdwv_pkg::BK_SUM;
         fdwv_pkg::BK_SUM:  state_in = fdwv_pkg::BK_SQ;
         fdwv_pkg::BK_SQ:   state_in = fdwv_pkg::BK_NQ;
         fdwv_pkg::BK_NQ:   state_in = fdwv_pkg::BK_PREP;
         fdwv_pkg::BK_PREP: state_in = fdwv_pkg::BK_DIV;
         fdwv_pkg::BK_DIV:  if (div_last) state_in = fdwv_pkg::BK_OUT;
         fdwv_pkg::BK_OUT:  if (out_load) state_in = fdwv_pkg::BK_IDLE;
         default:           state_in = fdwv_pkg::BK_IDLE;
      endcase
   end

   // Output decode
   always_comb begin
      pop      = 1'b0;
      win_we   = 1'b0;
      out_load = 1'b0;
      div_last = 1'b0;
      case (state_ff)
         fdwv_pkg::BK_IDLE: pop = !qstat.empty;
         fdwv_pkg::BK_SUM:  win_we = 1'b1;
         fdwv_pkg::BK_DIV:  div_last = (cnt_ff == CNT_W'(NUM_W - 1));
         fdwv_pkg::BK_OUT:  out_load = !rsp_valid_ff || rsp.ready;
         default: begin
         end
      endcase
   end

   // Window memory: one write port, one registered read at the oldest slot
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_ff[slot_ff] <= d_ff;
      end
      rd_ff <= win_ff[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdwv_pkg::BK_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (win_we) begin
            slot_ff <= slot_in;
            fill_ff <= fill_in;
            sum_ff  <= sum_in;
            sq_ff   <= sq_in;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         fdwv_pkg::BK_IDLE: begin
            d_ff   <= head;
            dsq_ff <= head_sq[SQR_W-1:0];
         end
         fdwv_pkg::BK_SQ: s2_ff <= NUM_W'(mag) * NUM_W'(mag);
         fdwv_pkg::BK_NQ: num_ff <= NUM_W'(nq);
         fdwv_pkg::BK_PREP: begin
            quo_ff <= (num_ff > s2_ff) ? num_ff - s2_ff : '0;
            den_ff <= DEN_W'(fill_ff) * DEN_W'(fill_ff);
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         fdwv_pkg::BK_DIV: begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[NUM_W-2:0], ge};
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
      if (out_load) begin
         rsp_var_ff  <= quo_ff[VAR_W-1:0];
         rsp_diff_ff <= d_ff;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.variance        = rsp_var_ff;
   assign rsp.step_difference = rsp_diff_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_LENGTH))
      else $error("window fill beyond window length");
   a_fill_sticks: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == FILL_W'(WINDOW_LENGTH)) |=> (fill_ff == FILL_W'(WINDOW_LENGTH)))
      else $error("window fill dropped after window filled");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fdwv_pkg::BK_DIV) |-> (den_ff != '0))
      else $error("division by zero fill");

endmodule

`default_nettype wire

/* rtl/core/footstep_drift_window_variance_top.sv */
// Footstep drift window variance.
// req_bus carries one footfall per item: foot (0..3) and its forward
// stance position stance_x, signed Q16.16. rsp_bus returns exactly one item
// per footfall, in order: step_difference (the new position minus that
// foot's previous one, zero on a foot's first touchdown, saturated to 24
// bits) and variance, the unsigned Q15.32 variance of the last
// WINDOW_LENGTH differences (fewer until the window has filled).
// The front stage forms a footfall's difference as it accepts it and parks it in
// a QUEUE_DEPTH-entry queue, so req_bus keeps accepting while results wait.
// The back stage works one item at a time: pop, window update, the S*S and
// n*Q products, dividend prep, a restoring divider that retires one quotient
// bit per cycle over 2*(24+clog2(WINDOW_LENGTH+1)) bits, then the output load.
// For a window of 12 the dividend is 56 bits wide; the divider sets the rate.
// Reset (synchronous, active high) clears foot history, window fill and
// running sums; window contents are never read before being written.
// When rsp_bus stalls, the result holds in the output register, the back
// stage waits in its output step, and req_bus drops ready once the queue fills.
`default_nettype none

module footstep_drift_window_variance_top #(
   parameter int WINDOW_LENGTH = fdwv_pkg::WINDOW_LENGTH_DEF,
   parameter int QUEUE_DEPTH   = fdwv_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   fdwv_req_if.sink      req_bus,
   fdwv_rsp_if.source    rsp_bus
);

   // Queue link between front and back
   fdwv_pkg::q_stat_type                qstat;
   logic                                push;
   logic                                pop;
   logic signed [fdwv_pkg::DIFF_W-1:0]  push_data;
   logic signed [fdwv_pkg::DIFF_W-1:0]  head;

   // Accept footfalls, track per-foot history, form the saturated difference
   fdwv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   // Decouple the front, which accepts while the queue has room, from the slow back
   fdwv_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (qstat)
   );

   // Window, running sums, variance divide and output register
   fdwv_back #(
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .qstat (qstat),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

endmodule

`default_nettype wire
